@@ src/kernel_convolution_clamp_assert.svh @@
// Assertion macros for the convolution block.
// Used by the top level only; expects signals named clock and reset in scope.
`ifndef KERNEL_CONVOLUTION_CLAMP_ASSERT_SVH
`define KERNEL_CONVOLUTION_CLAMP_ASSERT_SVH
`define KCC_ASSERT_ALWAYS(lbl, expr, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (expr)) else $error(msg);
`define KCC_ASSERT_NEXT(lbl, pre, post, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (pre) |=> (post)) else $error(msg);
`endif

@@ src/kcc_pkg.sv @@
// Shared types and constants of the convolution block.
// No dependencies; every other file but the assertion header imports it.
`default_nettype none
package kcc_pkg;
   localparam int PIX_BITS      = 8;
   localparam int PIX_MAX       = 255;
   localparam int KROWS         = 5;
   localparam int COEF_ROW_BITS = 60;
   localparam int FW_BITS       = 11;
   localparam int FH_BITS       = 12;
   localparam int SHIFT_BITS    = 4;
   localparam int CSR_ADDR_BITS = 6;
   localparam int CSR_DATA_BITS = 64;
   localparam int REG_SEL_LSB   = 3;
   localparam int REG_SEL_BITS  = 3;

   localparam logic [FW_BITS-1:0]    FW_RESET    = 11'd1024;
   localparam logic [FH_BITS-1:0]    FH_RESET    = 12'd768;
   localparam logic [SHIFT_BITS-1:0] SHIFT_RESET = 4'd0;

   typedef enum logic [REG_SEL_BITS-1:0] {
      REG_COEF_ROW_0   = 3'd0,
      REG_COEF_ROW_1   = 3'd1,
      REG_COEF_ROW_2   = 3'd2,
      REG_COEF_ROW_3   = 3'd3,
      REG_COEF_ROW_4   = 3'd4,
      REG_FRAME_WIDTH  = 3'd5,
      REG_FRAME_HEIGHT = 3'd6,
      REG_COEF_SHIFT   = 3'd7
   } reg_index_type;

   typedef struct packed {
      logic rd_en;
      logic wr_en;
   } line_ctl_type;

   typedef struct packed {
      logic shift_en;
      logic calc_en;
   } cell_ctl_type;
endpackage
`default_nettype wire

@@ src/kcc_if.sv @@
// Valid/ready stream interfaces for pixels in and filtered pixels out.
// Depends on kcc_pkg for the pixel width.
`default_nettype none
interface kcc_req_if;
   import kcc_pkg::*;
   logic                valid;
   logic                ready;
   logic [PIX_BITS-1:0] pixel_in;
   logic                drain;
   modport source (output valid, output pixel_in, output drain, input ready);
   modport sink (input valid, input pixel_in, input drain, output ready);
endinterface

interface kcc_rsp_if;
   import kcc_pkg::*;
   logic                valid;
   logic                ready;
   logic [PIX_BITS-1:0] pixel_out;
   logic                frame_end;
   modport source (output valid, output pixel_out, output frame_end, input ready);
   modport sink (input valid, input pixel_out, input frame_end, output ready);
endinterface
`default_nettype wire

@@ src/kernel_convolution_clamp.sv @@
// Pipeline: stages s1 to s5, then the output register, follow the transfer of the item
// that completes a window; that item arrives MAX_RADIUS rows plus MAX_RADIUS pixels
// after the centre pixel. Throughput: one transfer per cycle while the skid stage is empty,
// set by the 2*MAX_RADIUS line memories (one read and one write port each) and the cell row.
// Reset: synchronous, active high; counters, valids and configuration registers return
// to their reset values at once, with no clearing pass over the line memories.
`default_nettype none
`include "kernel_convolution_clamp_assert.svh"
module kernel_convolution_clamp #(
   parameter int MAX_WIDTH  = 1024,
   parameter int MAX_RADIUS = 2,
   parameter int COEF_BITS  = 12
) (
   input  wire                                clock,
   input  wire                                reset,
   kcc_req_if.sink                            req_bus,
   kcc_rsp_if.source                          rsp_bus,
   input  wire                                csr_psel,
   input  wire                                csr_penable,
   input  wire                                csr_pwrite,
   input  wire  [kcc_pkg::CSR_ADDR_BITS-1:0]  csr_paddr,
   input  wire  [kcc_pkg::CSR_DATA_BITS-1:0]  csr_pwdata,
   output logic [kcc_pkg::CSR_DATA_BITS-1:0]  csr_prdata,
   output logic                               csr_pready
);
   import kcc_pkg::*;

   localparam int KDIM     = 2 * MAX_RADIUS + 1;
   localparam int NLINES   = 2 * MAX_RADIUS;
   localparam int AW       = $clog2(MAX_WIDTH);
   localparam int WW       = $clog2(MAX_WIDTH + 1);
   localparam int RW       = FH_BITS + 1;
   localparam int PRE_BITS = $clog2(MAX_RADIUS * MAX_WIDTH + MAX_RADIUS + 1);
   localparam int PW       = COEF_BITS + PIX_BITS + 1;
   localparam int SW       = PW + $clog2(KDIM * KDIM);
   localparam int SW1      = SW + 1;

   // Configuration registers.
   logic [COEF_ROW_BITS-1:0] coef_row_ff [KROWS];
   logic [FW_BITS-1:0]       fw_ff;
   logic [FH_BITS-1:0]       fh_ff;
   logic [SHIFT_BITS-1:0]    shift_ff;
   logic                     csr_wr;
   reg_index_type            csr_idx;

   assign csr_wr     = csr_psel && csr_penable && csr_pwrite;
   assign csr_idx    = reg_index_type'(csr_paddr[REG_SEL_LSB +: REG_SEL_BITS]);
   assign csr_pready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k < KROWS; k++) begin
            coef_row_ff[k] <= '0;
         end
         fw_ff    <= FW_RESET;
         fh_ff    <= FH_RESET;
         shift_ff <= SHIFT_RESET;
      end else if (csr_wr) begin
         case (csr_idx)
            REG_COEF_ROW_0:   coef_row_ff[0] <= csr_pwdata[COEF_ROW_BITS-1:0];
            REG_COEF_ROW_1:   coef_row_ff[1] <= csr_pwdata[COEF_ROW_BITS-1:0];
            REG_COEF_ROW_2:   coef_row_ff[2] <= csr_pwdata[COEF_ROW_BITS-1:0];
            REG_COEF_ROW_3:   coef_row_ff[3] <= csr_pwdata[COEF_ROW_BITS-1:0];
            REG_COEF_ROW_4:   coef_row_ff[4] <= csr_pwdata[COEF_ROW_BITS-1:0];
            REG_FRAME_WIDTH:  fw_ff          <= csr_pwdata[FW_BITS-1:0];
            REG_FRAME_HEIGHT: fh_ff          <= csr_pwdata[FH_BITS-1:0];
            REG_COEF_SHIFT:   shift_ff       <= csr_pwdata[SHIFT_BITS-1:0];
            default: begin
            end
         endcase
      end
   end

   always_comb begin
      case (csr_idx)
         REG_COEF_ROW_0:   csr_prdata = CSR_DATA_BITS'(coef_row_ff[0]);
         REG_COEF_ROW_1:   csr_prdata = CSR_DATA_BITS'(coef_row_ff[1]);
         REG_COEF_ROW_2:   csr_prdata = CSR_DATA_BITS'(coef_row_ff[2]);
         REG_COEF_ROW_3:   csr_prdata = CSR_DATA_BITS'(coef_row_ff[3]);
         REG_COEF_ROW_4:   csr_prdata = CSR_DATA_BITS'(coef_row_ff[4]);
         REG_FRAME_WIDTH:  csr_prdata = CSR_DATA_BITS'(fw_ff);
         REG_FRAME_HEIGHT: csr_prdata = CSR_DATA_BITS'(fh_ff);
         REG_COEF_SHIFT:   csr_prdata = CSR_DATA_BITS'(shift_ff);
         default:          csr_prdata = '0;
      endcase
   end

   // Effective frame size and start-up delay.
   logic [WW-1:0]       w_eff;
   logic [FH_BITS-1:0]  h_eff;
   logic [PRE_BITS-1:0] lat;

   always_comb begin
      if (fw_ff == '0) begin
         w_eff = WW'(1);
      end else if (32'(fw_ff) > 32'(MAX_WIDTH)) begin
         w_eff = WW'(MAX_WIDTH);
      end else begin
         w_eff = WW'(fw_ff);
      end
      h_eff = (fh_ff == '0) ? FH_BITS'(1) : fh_ff;
      lat   = PRE_BITS'(MAX_RADIUS * int'(w_eff) + MAX_RADIUS);
   end

   // Position counters and the accept stage.
   logic                adv;
   logic                accept;
   logic [AW-1:0]       col_ff, col_in;
   logic [RW-1:0]       row_ff, row_in;
   logic [AW-1:0]       qc_ff, qc_in;
   logic [RW-1:0]       qr_ff, qr_in;
   logic [PRE_BITS-1:0] pre_ff, pre_in;
   logic                started_ff, started_in;
   logic                started_now;
   logic                emit0;
   logic                last0;
   logic                end0;
   logic [PIX_BITS-1:0] pix0;
   logic [KDIM-1:0]     rmask0;
   logic [KDIM-1:0]     cmask0;
   logic                q_row_last;
   logic                q_col_last;

   assign accept         = req_bus.valid && adv;
   assign req_bus.ready  = adv;

   always_comb begin
      started_now = started_ff || (pre_ff == lat);
      q_row_last  = (qr_ff == RW'(h_eff) - RW'(1));
      q_col_last  = (WW'(qc_ff) == w_eff - WW'(1));
      emit0       = started_now && (qr_ff < RW'(h_eff));
      end0        = emit0 && q_row_last && q_col_last;
      last0       = started_now && ((qr_ff > RW'(h_eff) - RW'(1)) ||
                                    (q_row_last && q_col_last));
      pix0        = (!req_bus.drain && (row_ff < RW'(h_eff))) ? req_bus.pixel_in : '0;
      for (int i = 0; i < KDIM; i++) begin
         rmask0[i] = (32'(qr_ff) + 32'(i) >= 32'(MAX_RADIUS)) &&
                     (32'(qr_ff) + 32'(i) < 32'(h_eff) + 32'(MAX_RADIUS));
         cmask0[i] = (32'(qc_ff) + 32'(i) >= 32'(MAX_RADIUS)) &&
                     (32'(qc_ff) + 32'(i) < 32'(w_eff) + 32'(MAX_RADIUS));
      end

      col_in     = col_ff;
      row_in     = row_ff;
      qc_in      = qc_ff;
      qr_in      = qr_ff;
      pre_in     = pre_ff;
      started_in = started_ff;
      if (accept) begin
         if (last0) begin
            col_in     = '0;
            row_in     = '0;
            qc_in      = '0;
            qr_in      = '0;
            pre_in     = '0;
            started_in = 1'b0;
         end else begin
            if (WW'(col_ff) + WW'(1) >= w_eff) begin
               col_in = '0;
               row_in = row_ff + RW'(1);
            end else begin
               col_in = col_ff + AW'(1);
            end
            if (started_now) begin
               started_in = 1'b1;
               if (WW'(qc_ff) + WW'(1) >= w_eff) begin
                  qc_in = '0;
                  qr_in = qr_ff + RW'(1);
               end else begin
                  qc_in = qc_ff + AW'(1);
               end
            end else begin
               pre_in = pre_ff + PRE_BITS'(1);
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff     <= '0;
         row_ff     <= '0;
         qc_ff      <= '0;
         qr_ff      <= '0;
         pre_ff     <= '0;
         started_ff <= 1'b0;
      end else begin
         col_ff     <= col_in;
         row_ff     <= row_in;
         qc_ff      <= qc_in;
         qr_ff      <= qr_in;
         pre_ff     <= pre_in;
         started_ff <= started_in;
      end
   end

   // Pipeline valids.
   logic s1_v_ff, s2_v_ff, s3_v_ff, s4_v_ff, s5_v_ff;
   logic s1_v_in, s2_v_in, s3_v_in, s4_v_in, s5_v_in;
   logic s1_emit_ff;

   assign s1_v_in = adv ? accept : s1_v_ff;
   assign s2_v_in = adv ? (s1_v_ff && s1_emit_ff) : s2_v_ff;
   assign s3_v_in = adv ? s2_v_ff : s3_v_ff;
   assign s4_v_in = adv ? s3_v_ff : s4_v_ff;
   assign s5_v_in = adv ? s4_v_ff : s5_v_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_v_ff <= 1'b0;
         s2_v_ff <= 1'b0;
         s3_v_ff <= 1'b0;
         s4_v_ff <= 1'b0;
         s5_v_ff <= 1'b0;
      end else begin
         s1_v_ff <= s1_v_in;
         s2_v_ff <= s2_v_in;
         s3_v_ff <= s3_v_in;
         s4_v_ff <= s4_v_in;
         s5_v_ff <= s5_v_in;
      end
   end

   // Pipeline payload.
   logic [PIX_BITS-1:0] s1_pix_ff;
   logic [AW-1:0]       s1_addr_ff;
   logic                s1_end_ff, s2_end_ff, s3_end_ff, s4_end_ff, s5_end_ff;
   logic [KDIM-1:0]     s1_rmask_ff, s2_rmask_ff;
   logic [KDIM-1:0]     s1_cmask_ff, s2_cmask_ff;

   always_ff @(posedge clock) begin
      if (accept) begin
         s1_pix_ff   <= pix0;
         s1_addr_ff  <= col_ff;
         s1_emit_ff  <= emit0;
         s1_end_ff   <= end0;
         s1_rmask_ff <= rmask0;
         s1_cmask_ff <= cmask0;
      end
      if (adv) begin
         s2_end_ff   <= s1_end_ff;
         s2_rmask_ff <= s1_rmask_ff;
         s2_cmask_ff <= s1_cmask_ff;
         s3_end_ff   <= s2_end_ff;
         s4_end_ff   <= s3_end_ff;
         s5_end_ff   <= s4_end_ff;
      end
   end

   // Line delays: tap k is the stream delayed by k rows.
   logic [PIX_BITS-1:0] tap [NLINES+1];
   line_ctl_type        line_ctl;

   assign tap[0]         = s1_pix_ff;
   assign line_ctl.rd_en = accept;
   assign line_ctl.wr_en = adv && s1_v_ff;

   for (genvar k = 0; k < NLINES; k++) begin : g_line
      kcc_line #(
         .DEPTH(MAX_WIDTH),
         .AW   (AW)
      ) u_line (
         .clock  (clock),
         .ctl    (line_ctl),
         .rd_addr(col_ff),
         .wr_addr(s1_addr_ff),
         .wr_data(tap[k]),
         .rd_data(tap[k+1])
      );
   end

   // Window cells.
   logic [COEF_ROW_BITS+3:0]     coef_row64 [KROWS];
   logic [PIX_BITS-1:0]          cell_pix  [KDIM][KDIM];
   logic signed [PW-1:0]         cell_prod [KDIM][KDIM];
   logic signed [COEF_BITS-1:0]  coef      [KDIM][KDIM];
   cell_ctl_type                 cell_ctl;

   assign cell_ctl.shift_en = adv && s1_v_ff;
   assign cell_ctl.calc_en  = adv;

   for (genvar r = 0; r < KROWS; r++) begin : g_row64
      assign coef_row64[r] = {4'b0000, coef_row_ff[r]};
   end

   for (genvar i = 0; i < KDIM; i++) begin : g_wrow
      for (genvar j = 0; j < KDIM; j++) begin : g_wcol
         logic [PIX_BITS-1:0] shift_src;
         if (i < KROWS && (j + 1) * COEF_BITS <= 64) begin : g_coef
            assign coef[i][j] = $signed(coef_row64[i][j*COEF_BITS +: COEF_BITS]);
         end else begin : g_zero
            assign coef[i][j] = '0;
         end
         if (j == KDIM - 1) begin : g_head
            assign shift_src = tap[KDIM-1-i];
         end else begin : g_link
            assign shift_src = cell_pix[i][j+1];
         end
         kcc_cell #(
            .COEF_BITS(COEF_BITS),
            .PROD_BITS(PW)
         ) u_cell (
            .clock   (clock),
            .ctl     (cell_ctl),
            .pix_in  (shift_src),
            .keep    (s2_rmask_ff[i] && s2_cmask_ff[j]),
            .coef    (coef[i][j]),
            .pix_out (cell_pix[i][j]),
            .prod_out(cell_prod[i][j])
         );
      end
   end

   // Adder tree: row sums, then the total.
   logic signed [SW-1:0] rsum_in [KDIM];
   logic signed [SW-1:0] rsum_ff [KDIM];
   logic signed [SW-1:0] total_in;
   logic signed [SW-1:0] total_ff;

   always_comb begin
      for (int i = 0; i < KDIM; i++) begin
         rsum_in[i] = '0;
         for (int j = 0; j < KDIM; j++) begin
            rsum_in[i] = rsum_in[i] + SW'(cell_prod[i][j]);
         end
      end
      total_in = '0;
      for (int i = 0; i < KDIM; i++) begin
         total_in = total_in + rsum_ff[i];
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         for (int i = 0; i < KDIM; i++) begin
            rsum_ff[i] <= rsum_in[i];
         end
         total_ff <= total_in;
      end
   end

   // Rounding and clamping.
   logic signed [SW1-1:0] half;
   logic signed [SW1-1:0] rnd;
   logic signed [SW1-1:0] shd;
   logic [PIX_BITS-1:0]   res_pix;

   always_comb begin
      half = (shift_ff == '0) ? '0 : (SW1'(1) <<< (shift_ff - SHIFT_BITS'(1)));
      rnd  = SW1'(total_ff) + half;
      shd  = rnd >>> shift_ff;
      if (shd < 0) begin
         res_pix = '0;
      end else if (shd > SW1'(PIX_MAX)) begin
         res_pix = PIX_BITS'(PIX_MAX);
      end else begin
         res_pix = shd[PIX_BITS-1:0];
      end
   end

   // Output register with skid stage.
   logic                res_v;
   logic                out_v_ff, out_v_in;
   logic                skid_v_ff, skid_v_in;
   logic [PIX_BITS-1:0] out_pix_ff, out_pix_in, skid_pix_ff, skid_pix_in;
   logic                out_end_ff, out_end_in, skid_end_ff, skid_end_in;

   assign adv   = !skid_v_ff;
   assign res_v = adv && s5_v_ff;

   always_comb begin
      out_v_in    = out_v_ff;
      out_pix_in  = out_pix_ff;
      out_end_in  = out_end_ff;
      skid_v_in   = skid_v_ff;
      skid_pix_in = skid_pix_ff;
      skid_end_in = skid_end_ff;
      if (skid_v_ff) begin
         if (rsp_bus.ready) begin
            out_pix_in = skid_pix_ff;
            out_end_in = skid_end_ff;
            skid_v_in  = 1'b0;
         end
      end else if (res_v) begin
         if (!out_v_ff || rsp_bus.ready) begin
            out_v_in   = 1'b1;
            out_pix_in = res_pix;
            out_end_in = s5_end_ff;
         end else begin
            skid_v_in   = 1'b1;
            skid_pix_in = res_pix;
            skid_end_in = s5_end_ff;
         end
      end else if (rsp_bus.ready) begin
         out_v_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_v_ff  <= 1'b0;
         skid_v_ff <= 1'b0;
      end else begin
         out_v_ff  <= out_v_in;
         skid_v_ff <= skid_v_in;
      end
      out_pix_ff  <= out_pix_in;
      out_end_ff  <= out_end_in;
      skid_pix_ff <= skid_pix_in;
      skid_end_ff <= skid_end_in;
   end

   assign rsp_bus.valid     = out_v_ff;
   assign rsp_bus.pixel_out = out_pix_ff;
   assign rsp_bus.frame_end = out_end_ff;

   `KCC_ASSERT_ALWAYS(a_skid_behind_out, !skid_v_ff || out_v_ff, "skid full, output empty")
   `KCC_ASSERT_NEXT(a_stall_fills_skid, res_v && out_v_ff && !rsp_bus.ready, skid_v_ff, "lost")
   `KCC_ASSERT_NEXT(a_frame_restart, accept && last0, !started_ff && (row_ff | qr_ff) == '0, "no restart")
endmodule
`default_nettype wire

@@ src/kcc_cell.sv @@
// One window cell: holds a pixel, passes it to its neighbour and forms its product.
// Depends on kcc_pkg.
`default_nettype none
module kcc_cell #(
   parameter int COEF_BITS = 12,
   parameter int PROD_BITS = 21
) (
   input  wire                           clock,
   input  wire kcc_pkg::cell_ctl_type    ctl,
   input  wire  [kcc_pkg::PIX_BITS-1:0]  pix_in,
   input  wire                           keep,
   input  wire  signed [COEF_BITS-1:0]   coef,
   output logic [kcc_pkg::PIX_BITS-1:0]  pix_out,
   output logic signed [PROD_BITS-1:0]   prod_out
);
   import kcc_pkg::*;

   logic [PIX_BITS-1:0]         pix_ff;
   logic signed [PROD_BITS-1:0] prod_ff;
   logic signed [PROD_BITS-1:0] prod_in;
   logic signed [PROD_BITS-1:0] coef_ext;
   logic signed [PROD_BITS-1:0] pix_ext;

   always_comb begin
      coef_ext = PROD_BITS'(coef);
      pix_ext  = keep ? $signed(PROD_BITS'(pix_ff)) : '0;
      prod_in  = coef_ext * pix_ext;
   end

   always_ff @(posedge clock) begin
      if (ctl.shift_en) begin
         pix_ff <= pix_in;
      end
      if (ctl.calc_en) begin
         prod_ff <= prod_in;
      end
   end

   assign pix_out  = pix_ff;
   assign prod_out = prod_ff;
endmodule
`default_nettype wire

@@ src/kcc_line.sv @@
// One line delay: a row-long memory addressed by column, with write-to-read bypass.
// Depends on kcc_pkg.
`default_nettype none
module kcc_line #(
   parameter int DEPTH = 1024,
   parameter int AW    = 10
) (
   input  wire                           clock,
   input  wire kcc_pkg::line_ctl_type    ctl,
   input  wire  [AW-1:0]                 rd_addr,
   input  wire  [AW-1:0]                 wr_addr,
   input  wire  [kcc_pkg::PIX_BITS-1:0]  wr_data,
   output logic [kcc_pkg::PIX_BITS-1:0]  rd_data
);
   import kcc_pkg::*;

   logic [PIX_BITS-1:0] mem [DEPTH];
   logic [PIX_BITS-1:0] rd_ff;
   logic [PIX_BITS-1:0] byp_data_ff;
   logic                byp_ff;
   logic                byp_in;

   assign byp_in = ctl.wr_en && (wr_addr == rd_addr);

   always_ff @(posedge clock) begin
      if (ctl.wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.rd_en) begin
         rd_ff       <= mem[rd_addr];
         byp_ff      <= byp_in;
         byp_data_ff <= wr_data;
      end
   end

   assign rd_data = byp_ff ? byp_data_ff : rd_ff;
endmodule
`default_nettype wire

@@ test/kernel_convolution_clamp_tb.sv @@
// Self-checking testbench for kernel_convolution_clamp: random kernels and frames
// streamed through the valid/ready channels and checked against an in-bench model.
// Depends on kcc_pkg, the kcc_req_if and kcc_rsp_if interfaces and the block itself.
`timescale 1ns / 100ps
module kernel_convolution_clamp_tb;
   import kcc_pkg::*;

   localparam int RADIUS = 2;
   localparam int WIDTH_CAP = 1024;
   localparam int HIST_LEN = 2 * RADIUS * WIDTH_CAP + 2 * RADIUS + 1;
   localparam int STALL_LIMIT = 3000;

   typedef struct {
      logic [7:0] pixel;
      logic       drain;
   } pixel_item_type;

   typedef struct {
      logic [7:0] pixel;
      logic       frame_end;
   } filtered_type;

   logic clock = 0;
   logic reset = 1;
   logic csr_psel = 0, csr_penable = 0, csr_pwrite = 0;
   logic [CSR_ADDR_BITS-1:0] csr_paddr = '0;
   logic [CSR_DATA_BITS-1:0] csr_pwdata = '0;
   logic [CSR_DATA_BITS-1:0] csr_prdata;
   logic csr_pready;

   kcc_req_if req ();
   kcc_rsp_if rsp ();

   kernel_convolution_clamp dut (
      .clock(clock), .reset(reset), .req_bus(req), .rsp_bus(rsp),
      .csr_psel(csr_psel), .csr_penable(csr_penable), .csr_pwrite(csr_pwrite),
      .csr_paddr(csr_paddr), .csr_pwdata(csr_pwdata), .csr_prdata(csr_prdata),
      .csr_pready(csr_pready)
   );

   always begin
      #2 clock = 1;
      #2 clock = 0;
   end

   // Mirror of the block's registers and state.
   logic [COEF_ROW_BITS-1:0] kernel_rows [KROWS];
   logic [FW_BITS-1:0] frame_w = FW_RESET;
   logic [FH_BITS-1:0] frame_h = FH_RESET;
   logic [SHIFT_BITS-1:0] round_shift = SHIFT_RESET;
   logic [7:0] history [HIST_LEN];
   int col_pos = 0, row_pos = 0;

   pixel_item_type pending_pixels[$];
   filtered_type expected_pixels[$];
   int errors = 0;
   bit steady = 0;
   bit hold_request = 0;
   int hold_left = 0;
   int quiet_cycles = 0;

   function automatic int eff_width();
      return (frame_w == 0) ? 1 : (frame_w > WIDTH_CAP) ? WIDTH_CAP : int'(frame_w);
   endfunction

   function automatic int eff_height();
      return (frame_h == 0) ? 1 : int'(frame_h);
   endfunction

   task automatic convolve_item(input logic [7:0] pix_in, input logic drn);
      int w, h, lat, total, t, q, r, c, rr, cc;
      longint acc, res;
      logic [7:0] v;
      logic signed [11:0] coef;
      filtered_type f;
      w = eff_width();
      h = eff_height();
      lat = RADIUS * w + RADIUS;
      total = w * h;
      t = row_pos * w + col_pos;
      history[t % HIST_LEN] = (!drn && t < total) ? pix_in : 8'd0;
      if (t >= lat) begin
         q = t - lat;
         if (q < total) begin
            r = q / w;
            c = q % w;
            acc = 0;
            for (int i = 0; i < 5; i++) begin
               for (int j = 0; j < 5; j++) begin
                  rr = r + i - RADIUS;
                  cc = c + j - RADIUS;
                  v = 0;
                  if (rr >= 0 && rr < h && cc >= 0 && cc < w)
                     v = history[(rr * w + cc) % HIST_LEN];
                  coef = kernel_rows[i][j*12 +: 12];
                  acc += longint'(coef) * longint'(v);
               end
            end
            if (round_shift != 0) acc += longint'(1) << (round_shift - 1);
            res = acc >>> round_shift;
            if (res < 0) res = 0;
            if (res > PIX_MAX) res = PIX_MAX;
            f.pixel = res[7:0];
            f.frame_end = (q == total - 1);
            expected_pixels.push_back(f);
         end
         if (q >= total - 1) begin
            row_pos = 0;
            col_pos = 0;
            return;
         end
      end
      col_pos++;
      if (col_pos >= w) begin
         col_pos = 0;
         row_pos++;
      end
   endtask

   // Driver: predicts on each accepted transfer, then offers the next item.
   always @(posedge clock) begin
      if (reset) begin
         req.valid <= 0;
         req.pixel_in <= '0;
         req.drain <= 0;
      end else begin
         if (req.valid && req.ready) convolve_item(req.pixel_in, req.drain);
         if (!req.valid || req.ready) begin
            if (pending_pixels.size() > 0 && (steady || $urandom_range(0, 99) >= 19)) begin
               req.valid <= 1;
               req.pixel_in <= pending_pixels[0].pixel;
               req.drain <= pending_pixels[0].drain;
               pending_pixels.pop_front();
            end else begin
               req.valid <= 0;
            end
         end
      end
   end

   // Monitor: result checks, receiver stalls and the watchdog.
   always @(posedge clock) begin
      if (reset) begin
         rsp.ready <= 0;
      end else begin
         if (rsp.valid && rsp.ready) begin
            if (expected_pixels.size() == 0) begin
               $error("unexpected transfer: pixel_out %0d", rsp.pixel_out);
               errors++;
            end else begin
               if (rsp.pixel_out !== expected_pixels[0].pixel) begin
                  $error("pixel_out expected %0d actual %0d",
                         expected_pixels[0].pixel, rsp.pixel_out);
                  errors++;
               end
               if (rsp.frame_end !== expected_pixels[0].frame_end) begin
                  $error("frame_end expected %0d actual %0d",
                         expected_pixels[0].frame_end, rsp.frame_end);
                  errors++;
               end
               expected_pixels.pop_front();
            end
         end
         if ((rsp.valid && rsp.ready) || (req.valid && req.ready)) quiet_cycles = 0;
         else quiet_cycles++;
         if (quiet_cycles >= STALL_LIMIT) begin
            $display("CHECK FAILED");
            $finish;
         end
         if (hold_request) begin
            hold_request = 0;
            hold_left = 300;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp.ready <= 0;
         end else begin
            rsp.ready <= steady || $urandom_range(0, 99) >= 19;
         end
      end
   end

   task automatic write_reg(input reg_index_type idx, input logic [63:0] value);
      @(posedge clock);
      csr_psel <= 1;
      csr_penable <= 0;
      csr_pwrite <= 1;
      csr_paddr <= {idx, 3'b000};
      csr_pwdata <= value;
      @(posedge clock);
      csr_penable <= 1;
      @(posedge clock);
      csr_psel <= 0;
      csr_penable <= 0;
      csr_pwrite <= 0;
      case (idx)
         REG_FRAME_WIDTH: frame_w = value[FW_BITS-1:0];
         REG_FRAME_HEIGHT: frame_h = value[FH_BITS-1:0];
         REG_COEF_SHIFT: round_shift = value[SHIFT_BITS-1:0];
         default: kernel_rows[idx] = value[COEF_ROW_BITS-1:0];
      endcase
   endtask

   task automatic wait_idle();
      while (pending_pixels.size() > 0 || req.valid || expected_pixels.size() > 0)
         @(posedge clock);
      repeat (12) @(posedge clock);
   endtask

   function automatic logic [59:0] random_row(input int spread);
      logic [59:0] row;
      for (int j = 0; j < 5; j++) begin
         if ($urandom_range(0, 3) == 0) row[j*12 +: 12] = 12'($urandom);
         else row[j*12 +: 12] = 12'($urandom_range(0, 2 * spread) - spread);
      end
      return row;
   endfunction

   task automatic load_kernel(input int spread);
      write_reg(REG_COEF_ROW_0, 64'(random_row(spread)));
      write_reg(REG_COEF_ROW_1, 64'(random_row(spread)));
      write_reg(REG_COEF_ROW_2, 64'(random_row(spread)));
      write_reg(REG_COEF_ROW_3, 64'(random_row(spread)));
      write_reg(REG_COEF_ROW_4, 64'(random_row(spread)));
   endtask

   task automatic load_uniform(input logic [11:0] coef);
      logic [63:0] row;
      row = 64'({5{coef}});
      write_reg(REG_COEF_ROW_0, row);
      write_reg(REG_COEF_ROW_1, row);
      write_reg(REG_COEF_ROW_2, row);
      write_reg(REG_COEF_ROW_3, row);
      write_reg(REG_COEF_ROW_4, row);
   endtask

   task automatic push_pixels(input int count, input int drain_pct);
      pixel_item_type it;
      for (int k = 0; k < count; k++) begin
         it.pixel = 8'($urandom);
         it.drain = $urandom_range(0, 99) < drain_pct;
         pending_pixels.push_back(it);
      end
   endtask

   // Flushes the frame in flight until the position counters restart.
   task automatic finish_frame();
      int w, lat, total, t, rest;
      wait_idle();
      w = eff_width();
      lat = RADIUS * w + RADIUS;
      total = w * eff_height();
      t = row_pos * w + col_pos;
      rest = lat + total - t;
      if (rest < 1) rest = 1;
      push_pixels(rest, 75);
      wait_idle();
   endtask

   task automatic run_frame(input int w, input int h, input int s, input int drain_pct);
      write_reg(REG_FRAME_WIDTH, 64'(w));
      write_reg(REG_FRAME_HEIGHT, 64'(h));
      write_reg(REG_COEF_SHIFT, 64'(s));
      push_pixels(eff_width() * eff_height(), drain_pct);
      finish_frame();
   endtask

   initial begin
      int sent;
      for (int i = 0; i < KROWS; i++) kernel_rows[i] = '0;
      for (int i = 0; i < HIST_LEN; i++) history[i] = '0;
      repeat (10) @(posedge clock);
      reset <= 0;

      // Directed: identity kernel with extreme pixels and a drain inside the frame.
      write_reg(REG_COEF_ROW_0, '0);
      write_reg(REG_COEF_ROW_1, '0);
      write_reg(REG_COEF_ROW_2, 64'd1 << 24);
      write_reg(REG_COEF_ROW_3, '0);
      write_reg(REG_COEF_ROW_4, '0);
      write_reg(REG_FRAME_WIDTH, 64'd4);
      write_reg(REG_FRAME_HEIGHT, 64'd3);
      write_reg(REG_COEF_SHIFT, '0);
      pending_pixels.push_back('{8'd0, 1'b0});
      pending_pixels.push_back('{8'd255, 1'b0});
      pending_pixels.push_back('{8'd0, 1'b1});
      pending_pixels.push_back('{8'd255, 1'b0});
      push_pixels(8, 10);
      finish_frame();
      load_uniform(12'h7FF);
      run_frame(3, 3, 0, 0);
      load_uniform(12'h800);
      run_frame(3, 2, 11, 0);
      load_kernel(2047);
      run_frame(0, 0, 11, 0);
      run_frame(5, 1, 5, 5);
      run_frame(1, 7, 1, 5);

      // Height and shift changed in the middle of a frame.
      load_kernel(16);
      write_reg(REG_FRAME_WIDTH, 64'd6);
      write_reg(REG_FRAME_HEIGHT, 64'd5);
      push_pixels(17, 0);
      wait_idle();
      write_reg(REG_FRAME_HEIGHT, 64'd3);
      write_reg(REG_COEF_SHIFT, 64'd3);
      finish_frame();

      // Receiver held off while the sender keeps offering.
      write_reg(REG_FRAME_WIDTH, 64'd8);
      write_reg(REG_FRAME_HEIGHT, 64'd6);
      push_pixels(48, 0);
      hold_request = 1;
      finish_frame();

      sent = 0;
      while (sent < 450) begin
         int w, h;
         w = $urandom_range(1, 8);
         h = $urandom_range(1, 6);
         steady = (sent >= 150 && sent < 270);
         load_kernel($urandom_range(1, 64));
         run_frame(w, h, $urandom_range(0, 11), $urandom_range(0, 1) * 5);
         sent += w * h + 2 * w + 2;
      end
      steady = 0;

      wait_idle();
      if (errors == 0) begin
         $display("CHECK OK");
      end else begin
         $display("CHECK FAILED");
      end
      $finish;
   end
endmodule

@@ kernel_convolution_clamp.f @@
+incdir+src
src/kcc_pkg.sv
src/kcc_if.sv
src/kcc_cell.sv
src/kcc_line.sv
src/kernel_convolution_clamp.sv
test/kernel_convolution_clamp_tb.sv
